// File: design/vss_pkg.sv
// ----------------------------------------------------------------------------
// vss_pkg: velocity source selector shared definitions
// Request/response payload types, item and source codes, and fixed-point
// sizing for the acceleration window.
// ----------------------------------------------------------------------------
package vss_pkg;

   localparam int ACCEL_WINDOW = 9;

   localparam int SPEED_W = 16;
   localparam int THR_W   = 15;
   localparam int TS_W    = 32;
   localparam int ACC_W   = 24;
   localparam int MAG_W   = SPEED_W + 1;
   localparam int SCALE_W = 20;
   localparam int PROD_W  = 36;
   localparam int SUM_W   = ACC_W + $clog2(ACCEL_WINDOW + 1);
   localparam int PTR_W   = (ACCEL_WINDOW > 1) ? $clog2(ACCEL_WINDOW) : 1;
   localparam int CNT_W   = $clog2(ACCEL_WINDOW + 2);
   localparam int STEP_W  = $clog2(PROD_W + 1);

   localparam logic [SCALE_W-1:0] US_PER_S   = SCALE_W'(1000000);
   localparam logic [THR_W-1:0]   THR_RESET  = THR_W'(498);

   localparam logic [1:0] FUNC_CAN  = 2'd0;
   localparam logic [1:0] FUNC_GNSS = 2'd1;
   localparam logic [1:0] FUNC_LAMP = 2'd2;

   localparam logic [1:0] SRC_CAN_NO_GNSS = 2'd0;
   localparam logic [1:0] SRC_GNSS_SLOW   = 2'd1;
   localparam logic [1:0] SRC_GNSS_FAST   = 2'd2;
   localparam logic [1:0] SRC_CAN_NORMAL  = 2'd3;

   typedef struct packed {
      logic [1:0]                func;
      logic signed [SPEED_W-1:0] speed;
      logic [TS_W-1:0]           timestamp_us;
      logic                      lamp_on;
   } req_type;

   typedef struct packed {
      logic [1:0]                chosen_source;
      logic signed [SPEED_W-1:0] chosen_speed;
      logic signed [SPEED_W-1:0] can_speed;
      logic signed [SPEED_W-1:0] gnss_speed;
   } rsp_type;

endpackage

// File: design/velocity_source_selector.sv
// ----------------------------------------------------------------------------
// velocity_source_selector: CAN / GNSS speed selection
// Tracks GNSS acceleration over a sliding window and picks the speed source
// for every CAN request.
// ----------------------------------------------------------------------------
//  Channel | Ports                         | Direction | Handshake
//  --------+-------------------------------+-----------+-----------------
//  request | req_valid/req_ready/req_data  | in        | valid/ready
//  result  | rsp_valid/rsp_ready/rsp_data  | out       | valid/ready
//  csr     | csr_write_enable/_data        | in        | write strobe
//
//  CAN request: registered on acceptance; S_CAN registers the result once the
//  result slot is free. Lamp and first GNSS requests complete in S_IDLE.
//  Later GNSS requests pass S_MUL, the restoring divider in S_DIV (one quotient
//  bit per cycle over 36 bits) and the window update in S_ACC.
//  Synchronous reset clears all control state and sets the threshold to 498.
//  A stalled result holds a CAN request in S_CAN; no request is taken meanwhile.
// ----------------------------------------------------------------------------
module velocity_source_selector (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  vss_pkg::req_type          req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output vss_pkg::rsp_type          rsp_data,
   input  logic                      csr_write_enable,
   input  logic [vss_pkg::THR_W-1:0] csr_write_data
);
   import vss_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CAN,
      S_MUL,
      S_DIV,
      S_ACC
   } state_type;

   localparam logic [PROD_W-1:0] POS_LIMIT = PROD_W'((64'd1 << (ACC_W - 1)) - 64'd1);
   localparam logic [PROD_W-1:0] NEG_LIMIT = PROD_W'(64'd1 << (ACC_W - 1));
   localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
   localparam logic signed [SPEED_W-1:0] SPD_MIN = {1'b1, {(SPEED_W-1){1'b0}}};
   localparam logic signed [SPEED_W-1:0] SPD_MAX = {1'b0, {(SPEED_W-1){1'b1}}};

   state_type                 state_ff, state_in;
   req_type                   req_ff, req_in;
   logic [THR_W-1:0]          thr_ff, thr_in;
   logic signed [SPEED_W-1:0] last_gnss_ff, last_gnss_in;
   logic [TS_W-1:0]           last_time_ff, last_time_in;
   logic [CNT_W-1:0]          seen_ff, seen_in;
   logic [PTR_W-1:0]          ptr_ff, ptr_in;
   logic signed [SUM_W-1:0]   sum_ff, sum_in;
   logic                      lamp_ff, lamp_in;
   logic [TS_W-1:0]           divisor_ff, divisor_in;
   logic [PROD_W-1:0]         quot_ff, quot_in;
   logic [TS_W:0]             rem_ff, rem_in;
   logic [STEP_W-1:0]         step_ff, step_in;
   logic                      neg_ff, neg_in;
   logic                      zero_ff, zero_in;
   rsp_type                   rsp_ff, rsp_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   logic signed [ACC_W-1:0]   ring [ACCEL_WINDOW];
   logic signed [ACC_W-1:0]   old_ff;
   logic                      ring_we;

   logic                      req_fire;
   logic                      slot_free;
   logic signed [MAG_W-1:0]   dv;
   logic [MAG_W-1:0]          mag;
   logic [PROD_W-1:0]         prod;
   logic [TS_W:0]             trial;
   logic                      ge;
   logic signed [ACC_W-1:0]   accel;
   logic                      ring_full;
   logic                      below;
   logic                      sum_neg;
   logic                      sum_pos;
   logic signed [SPEED_W-1:0] neg_speed;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign dv   = MAG_W'(req_ff.speed) - MAG_W'(last_gnss_ff);
   assign mag  = dv[MAG_W-1] ? MAG_W'(-dv) : MAG_W'(dv);
   assign prod = PROD_W'(mag) * PROD_W'(US_PER_S);

   assign trial = {rem_ff[TS_W-1:0], quot_ff[PROD_W-1]};
   assign ge    = (trial >= {1'b0, divisor_ff});

   always_comb begin
      if (zero_ff) begin
         accel = '0;
      end else if (neg_ff) begin
         accel = (quot_ff > NEG_LIMIT) ? ACC_MIN : ACC_W'(-quot_ff[ACC_W-1:0]);
      end else begin
         accel = (quot_ff > POS_LIMIT) ? ACC_MAX : quot_ff[ACC_W-1:0];
      end
   end

   assign ring_full = (seen_ff > CNT_W'(ACCEL_WINDOW));
   assign ring_we   = (state_ff == S_ACC);

   assign below     = $signed({req_ff.speed[SPEED_W-1], req_ff.speed}) <
                      $signed({2'b00, thr_ff});
   assign sum_neg   = sum_ff[SUM_W-1];
   assign sum_pos   = !sum_ff[SUM_W-1] && (sum_ff != '0);
   assign neg_speed = (req_ff.speed == SPD_MIN) ? SPD_MAX : SPEED_W'(-req_ff.speed);

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      thr_in       = thr_ff;
      last_gnss_in = last_gnss_ff;
      last_time_in = last_time_ff;
      seen_in      = seen_ff;
      ptr_in       = ptr_ff;
      sum_in       = sum_ff;
      lamp_in      = lamp_ff;
      divisor_in   = divisor_ff;
      quot_in      = quot_ff;
      rem_in       = rem_ff;
      step_in      = step_ff;
      neg_in       = neg_ff;
      zero_in      = zero_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (csr_write_enable) begin
         thr_in = csr_write_data;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               req_in = req_data;
               unique case (req_data.func)
                  FUNC_CAN: begin
                     state_in = S_CAN;
                  end
                  FUNC_GNSS: begin
                     if (seen_ff == '0) begin
                        seen_in      = CNT_W'(1);
                        last_gnss_in = req_data.speed;
                        last_time_in = req_data.timestamp_us;
                     end else begin
                        state_in = S_MUL;
                     end
                  end
                  FUNC_LAMP: begin
                     lamp_in = req_data.lamp_on;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_CAN: begin
            if (slot_free) begin
               rsp_valid_in     = 1'b1;
               rsp_in.can_speed = req_ff.speed;
               if (seen_ff == '0) begin
                  rsp_in.chosen_source = SRC_CAN_NO_GNSS;
                  rsp_in.chosen_speed  = req_ff.speed;
                  rsp_in.gnss_speed    = '0;
               end else begin
                  rsp_in.gnss_speed = last_gnss_ff;
                  priority if (below && (req_ff.speed > last_gnss_ff) && sum_neg) begin
                     rsp_in.chosen_source = SRC_GNSS_SLOW;
                     rsp_in.chosen_speed  = last_gnss_ff;
                  end else if (below && (req_ff.speed < last_gnss_ff) && sum_pos) begin
                     rsp_in.chosen_source = SRC_GNSS_FAST;
                     rsp_in.chosen_speed  = last_gnss_ff;
                  end else begin
                     rsp_in.chosen_source = SRC_CAN_NORMAL;
                     rsp_in.chosen_speed  = lamp_ff ? neg_speed : req_ff.speed;
                  end
               end
               state_in = S_IDLE;
            end
         end
         S_MUL: begin
            quot_in    = prod;
            rem_in     = '0;
            divisor_in = req_ff.timestamp_us - last_time_ff;
            step_in    = '0;
            neg_in     = dv[MAG_W-1];
            zero_in    = (dv == '0);
            state_in   = S_DIV;
         end
         S_DIV: begin
            rem_in  = ge ? (trial - {1'b0, divisor_ff}) : trial;
            quot_in = {quot_ff[PROD_W-2:0], ge};
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(PROD_W - 1)) begin
               state_in = S_ACC;
            end
         end
         S_ACC: begin
            sum_in = sum_ff - (ring_full ? SUM_W'(old_ff) : SUM_W'(0)) + SUM_W'(accel);
            ptr_in = (ptr_ff == PTR_W'(ACCEL_WINDOW - 1)) ? '0 : ptr_ff + PTR_W'(1);
            if (seen_ff <= CNT_W'(ACCEL_WINDOW)) begin
               seen_in = seen_ff + CNT_W'(1);
            end
            last_gnss_in = req_ff.speed;
            last_time_in = req_ff.timestamp_us;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         thr_ff       <= THR_RESET;
         last_gnss_ff <= '0;
         last_time_ff <= '0;
         seen_ff      <= '0;
         ptr_ff       <= '0;
         sum_ff       <= '0;
         lamp_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         thr_ff       <= thr_in;
         last_gnss_ff <= last_gnss_in;
         last_time_ff <= last_time_in;
         seen_ff      <= seen_in;
         ptr_ff       <= ptr_in;
         sum_ff       <= sum_in;
         lamp_ff      <= lamp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff     <= req_in;
      divisor_ff <= divisor_in;
      quot_ff    <= quot_in;
      rem_ff     <= rem_in;
      step_ff    <= step_in;
      neg_ff     <= neg_in;
      zero_ff    <= zero_in;
      rsp_ff     <= rsp_in;
   end

   // acceleration window
   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring[ptr_ff] <= accel;
      end
      old_ff <= ring[ptr_ff];
   end

`ifndef SYNTHESIS
   a_rsp_from_can: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == S_CAN))
      else $error("result raised without a CAN request");

   a_gnss_to_mul: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_data.func == FUNC_GNSS) && (seen_ff != '0)) |=> (state_ff == S_MUL))
      else $error("GNSS request did not start the divider");

   a_window_bounds: assert property (@(posedge clock) disable iff (reset)
      (seen_ff <= CNT_W'(ACCEL_WINDOW + 1)) &&
      ({1'b0, ptr_ff} < (PTR_W + 1)'(ACCEL_WINDOW)))
      else $error("window count or pointer out of range");
`endif

endmodule

// File: tb/tb_velocity_source_selector.sv
// ----------------------------------------------------------------------------
// tb_velocity_source_selector: self-checking bench for the speed source selector
// Drives CAN, GNSS and lamp requests with random idle bursts on both channels,
// tracks GNSS acceleration history in a local model and compares every result
// field against the predicted source and speed. The threshold register is
// rewritten between test phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_velocity_source_selector;
   timeunit 1ns;
   timeprecision 1ps;

   import vss_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 60;
   localparam longint ACCEL_MAX  = 64'sd8388607;
   localparam longint ACCEL_MIN  = -64'sd8388608;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   req_type          req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   rsp_type          rsp_data;
   logic             csr_write_enable = 1'b0;
   logic [THR_W-1:0] csr_write_data = '0;

   // selector model state
   int unsigned      threshold_setting = THR_RESET;
   int               can_speed_model = 0;
   int               gnss_speed_model = 0;
   logic [TS_W-1:0]  gnss_time_model = '0;
   int               gnss_count_model = 0;
   longint           accel_hist[ACCEL_WINDOW];
   int               hist_ptr = 0;
   longint           accel_total = 0;
   bit               lamp_model = 1'b0;
   rsp_type          pending_selections[$];

   bit               idle_enabled = 1'b1;
   int               fail_count = 0;
   int               quiet_cycles = 0;
   int               stall_left = 0;
   logic [TS_W-1:0]  gnss_clock_us = '0;

   velocity_source_selector i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #4 clock = ~clock;

   function automatic logic signed [SPEED_W-1:0] clamp_speed(int v);
      if (v > 32767) return 16'sh7FFF;
      if (v < -32768) return 16'sh8000;
      return SPEED_W'(v);
   endfunction

   function automatic int rand_speed();
      logic signed [SPEED_W-1:0] s;
      s = SPEED_W'($urandom);
      return int'(s);
   endfunction

   function automatic longint gnss_accel(longint dv, logic [TS_W-1:0] dt);
      longint q;
      if (dt == '0) begin
         if (dv > 0) return ACCEL_MAX;
         if (dv < 0) return ACCEL_MIN;
         return 0;
      end
      q = (dv * 64'sd1000000) / longint'(dt);
      if (q > ACCEL_MAX) q = ACCEL_MAX;
      if (q < ACCEL_MIN) q = ACCEL_MIN;
      return q;
   endfunction

   function automatic void predict_selection(req_type r);
      int         spd;
      int         chosen;
      bit         below;
      logic [1:0] src;
      longint     accel;
      rsp_type    res;
      spd = int'(r.speed);
      if (r.func == FUNC_GNSS) begin
         if (gnss_count_model >= 1) begin
            accel = gnss_accel(longint'(spd - gnss_speed_model),
                               r.timestamp_us - gnss_time_model);
            if (gnss_count_model > ACCEL_WINDOW) accel_total -= accel_hist[hist_ptr];
            accel_hist[hist_ptr] = accel;
            accel_total += accel;
            hist_ptr = (hist_ptr + 1) % ACCEL_WINDOW;
         end
         if (gnss_count_model <= ACCEL_WINDOW) gnss_count_model++;
         gnss_speed_model = spd;
         gnss_time_model = r.timestamp_us;
      end else if (r.func == FUNC_LAMP) begin
         lamp_model = r.lamp_on;
      end else if (r.func == FUNC_CAN) begin
         can_speed_model = spd;
         if (gnss_count_model == 0) begin
            src = SRC_CAN_NO_GNSS;
            chosen = spd;
         end else begin
            below = spd < int'(threshold_setting);
            if (below && spd > gnss_speed_model && accel_total < 0) begin
               src = SRC_GNSS_SLOW;
               chosen = gnss_speed_model;
            end else if (below && spd < gnss_speed_model && accel_total > 0) begin
               src = SRC_GNSS_FAST;
               chosen = gnss_speed_model;
            end else begin
               src = SRC_CAN_NORMAL;
               chosen = spd;
               if (lamp_model) chosen = (spd == -32768) ? 32767 : -spd;
            end
         end
         res.chosen_source = src;
         res.chosen_speed  = SPEED_W'(chosen);
         res.can_speed     = SPEED_W'(can_speed_model);
         res.gnss_speed    = (gnss_count_model != 0) ? SPEED_W'(gnss_speed_model) : '0;
         pending_selections = {pending_selections, res};
      end
   endfunction

   task automatic check_field(string name, logic signed [31:0] want,
                              logic signed [31:0] got);
      if (want !== got) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_selections.size() == 0) begin
            fail_count++;
            $display("%0t: unexpected result, expected none actual %h", $time, rsp_data);
         end else begin
            want = pending_selections.pop_front();
            check_field("chosen_source", want.chosen_source, rsp_data.chosen_source);
            check_field("chosen_speed", want.chosen_speed, rsp_data.chosen_speed);
            check_field("can_speed", want.can_speed, rsp_data.can_speed);
            check_field("gnss_speed", want.gnss_speed, rsp_data.gnss_speed);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else if (idle_enabled && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 4);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic send_request(logic [1:0] func, int speed, logic [TS_W-1:0] ts, bit lamp);
      req_type r;
      r.func = func;
      r.speed = clamp_speed(speed);
      r.timestamp_us = ts;
      r.lamp_on = lamp;
      if (idle_enabled && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_selection(r);
      @(negedge clock);
   endtask

   task automatic drain_requests();
      req_valid <= 1'b0;
      while (pending_selections.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_speed_threshold(logic [THR_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      threshold_setting = value;
   endtask

   // GNSS ramp with nearby CAN samples, so the GNSS branches get exercised
   task automatic send_drive_cycle(bit speeding_up, int unsigned top_speed);
      int v;
      int n;
      v = int'($urandom_range(0, 2 * top_speed)) - int'(top_speed);
      n = $urandom_range(3, 12);
      for (int k = 0; k < n; k++) begin
         if (speeding_up) v = int'(clamp_speed(v + int'($urandom_range(1, 200))));
         else v = int'(clamp_speed(v - int'($urandom_range(1, 200))));
         gnss_clock_us += TS_W'($urandom_range(20000, 200000));
         send_request(FUNC_GNSS, v, gnss_clock_us, 1'($urandom));
         if ($urandom_range(0, 1))
            send_request(FUNC_CAN, v + int'($urandom_range(0, 600)) - 300, $urandom,
                         1'($urandom));
      end
      if ($urandom_range(0, 5) == 0)
         send_request(FUNC_LAMP, rand_speed(), $urandom, 1'($urandom));
   endtask

   task automatic send_noise(int count);
      for (int k = 0; k < count; k++)
         send_request(2'($urandom_range(0, 3)), rand_speed(), $urandom, 1'($urandom));
   endtask

   task automatic test_directed_cases();
      send_request(FUNC_LAMP, 0, 0, 1'b1);
      send_request(FUNC_CAN, 0, 0, 1'b0);
      send_request(FUNC_CAN, 32767, '1, 1'b1);
      send_request(FUNC_CAN, -32768, 0, 1'b0);
      send_request(2'd3, 123, 32'h5555_5555, 1'b1);
      send_request(FUNC_GNSS, 2000, 100, 1'b0);
      send_request(FUNC_CAN, 32767, 0, 1'b0);
      send_request(FUNC_GNSS, 200, 100, 1'b0);
      send_request(FUNC_CAN, 300, 0, 1'b0);
      send_request(FUNC_GNSS, 200, 100, 1'b0);
      send_request(FUNC_GNSS, -32768, 32'hFFFF_FFF0, 1'b0);
      send_request(FUNC_GNSS, 32767, 16, 1'b1);
      send_request(FUNC_CAN, 100, 0, 1'b0);
      send_request(FUNC_GNSS, 32767, 1016, 1'b0);
      send_request(FUNC_GNSS, -32768, 1017, 1'b0);
      send_request(FUNC_CAN, -32768, 0, 1'b0);
      send_request(FUNC_LAMP, -1, '1, 1'b0);
      send_request(FUNC_CAN, -32768, 0, 1'b1);
      send_request(2'd3, -1, '1, 1'b1);
      send_request(FUNC_CAN, 497, 0, 1'b0);
      send_request(FUNC_CAN, 498, 0, 1'b0);
   endtask

   task automatic test_slowing_and_speeding();
      drain_requests();
      write_speed_threshold(THR_W'(8000));
      for (int k = 0; k < 18; k++) send_drive_cycle(1'($urandom), 3000);
   endtask

   task automatic test_threshold_extremes();
      drain_requests();
      write_speed_threshold('0);
      for (int k = 0; k < 5; k++) send_drive_cycle(1'($urandom), 2000);
      send_noise(20);
      drain_requests();
      write_speed_threshold('1);
      for (int k = 0; k < 5; k++) send_drive_cycle(1'($urandom), 30000);
      send_noise(20);
   endtask

   task automatic test_random_mix();
      drain_requests();
      write_speed_threshold(THR_W'($urandom));
      send_noise(80);
      for (int k = 0; k < 4; k++) send_drive_cycle(1'($urandom), 20000);
   endtask

   task automatic test_without_idle();
      drain_requests();
      write_speed_threshold(THR_RESET);
      idle_enabled = 1'b0;
      for (int k = 0; k < 6; k++) send_drive_cycle(1'($urandom), 600);
      send_noise(30);
   endtask

   initial begin
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed_cases();
      test_slowing_and_speeding();
      test_threshold_extremes();
      test_random_mix();
      test_without_idle();
      drain_requests();
      if (fail_count == 0 && pending_selections.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
